// ----- hw/rtl/group_selection_sampler_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the group selection sampler
// Concurrent checks that compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef GROUP_SELECTION_SAMPLER_ASSERT_SVH
`define GROUP_SELECTION_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define GSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSS_ASSERT(label, clk, rst_n, prop, msg)
`define GSS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/gss_pkg.sv -----
// ---------------------------------------------------------------------------
// Group selection sampler package
// Shared constants and register indexes.
// ---------------------------------------------------------------------------
package gss_pkg;
  localparam int unsigned GroupBitsDef = 24;
  localparam int unsigned MtN = 624;
  localparam int unsigned MtM = 397;
  localparam logic [31:0] SeedRst = 32'd5489;
  localparam logic [22:0] PctFull = 23'd6553600;
  // ceil(2^37 / 100): floor(n * PctRecip / 2^37) equals floor(n / 100) for n < 2^32
  localparam logic [30:0] PctRecip = 31'd1374389535;
  localparam logic [1:0] RegSeed = 2'd0;
  localparam logic [1:0] RegUseCount = 2'd1;
  localparam logic [1:0] RegSampleCount = 2'd2;
  localparam logic [1:0] RegPercent = 2'd3;

  // MT19937 output tempering
  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction
endpackage

// ----- hw/rtl/group_selection_sampler.sv -----
// ---------------------------------------------------------------------------
// Group selection sampler
// Per-group selection sampling driven by an MT19937 word source.
// ---------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | first_of_group_i, group_size_i
// out     | output    | out_valid/out_stall | selected_o
// cfg     | input     | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
// A row fetches the generator word, takes 31 remainder steps on the
// subtractor and registers the result; a row of an empty group skips the
// remainder, and a percent-mode first row adds 23 shift-add steps.
// Every 624th row also waits for the twist.
// After reset and after a seed write the state memory fills with the input
// stalled; a stalled result holds the next row in its done state.
module group_selection_sampler #(
  parameter int unsigned GROUP_BITS = gss_pkg::GroupBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first_of_group_i,
  input  logic [24:0] group_size_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        selected_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  // largest group; sizes on the 25-bit field never exceed it from 25 bits up
  localparam logic [25:0] SizeCap = (GROUP_BITS >= 25) ? 26'h1ff_ffff
                                                       : 26'(1 << GROUP_BITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PCT  = 5'b00010,
    S_WORD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } st_e;

  st_e         state_q, state_d;
  logic        use_count_q;
  logic [24:0] sample_count_q;
  logic [22:0] percent_q;
  logic [24:0] rem_q, rem_d;
  logic [24:0] need_q, need_d;
  logic [47:0] acc_q, acc_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [30:0] r_q, r_d;
  logic [25:0] md_q, md_d;
  logic        ovalid_q, ovalid_d;
  logic        sel_q, sel_d;
  logic        seed_we, mt_busy, mt_vld, mt_req;
  logic [31:0] mt_word;
  logic [24:0] gsize;
  logic [22:0] pct;
  logic [26:0] trial;
  logic        in_acc;
  logic [47:0] sum;
  logic [62:0] need_prod;

  assign cfg_ready = 1'b1;
  assign seed_we = cfg_valid && cfg_index_i == gss_pkg::RegSeed;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_count_q <= 1'b1;
      sample_count_q <= 25'd1;
      percent_q <= 23'd0;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        gss_pkg::RegUseCount: use_count_q <= cfg_data_i[0];
        gss_pkg::RegSampleCount: sample_count_q <= cfg_data_i[24:0];
        gss_pkg::RegPercent: percent_q <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  gss_mt u_mt (
    .clk_i, .rst_ni,
    .seed_we_i(seed_we), .seed_i(cfg_data_i),
    .req_i(mt_req), .busy_o(mt_busy), .word_vld_o(mt_vld), .word_o(mt_word)
  );

  assign in_stall = (state_q != S_IDLE) || mt_busy;
  assign in_acc = in_valid && !in_stall;
  assign gsize = ({1'b0, group_size_i} > SizeCap) ? SizeCap[24:0] : group_size_i;
  assign pct = (percent_q > gss_pkg::PctFull) ? gss_pkg::PctFull : percent_q;
  assign trial = {1'b0, md_q[24:0], r_q[30]} - {2'b00, rem_q};
  assign sum = acc_q + (48'(rem_q) << cnt_q[4:0]);
  // need = floor((acc >> 16) / 100) by reciprocal multiplication
  assign need_prod = acc_q[47:16] * gss_pkg::PctRecip;
  // ask for the word when a row is taken, or on the last percent product step
  assign mt_req = (in_acc && (use_count_q || !first_of_group_i)) ||
                  (state_q == S_PCT && cnt_q == 6'd22);

  // row sequencer
  always_comb begin
    state_d = state_q;
    rem_d = rem_q;
    need_d = need_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    r_d = r_q;
    md_d = md_q;
    ovalid_d = ovalid_q && out_stall;
    sel_d = sel_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_WORD;
          if (first_of_group_i) begin
            rem_d = gsize;
            if (use_count_q) begin
              need_d = (sample_count_q > gsize) ? gsize : sample_count_q;
            end else begin
              acc_d = 48'd0;
              cnt_d = 6'd0;
              state_d = S_PCT;
            end
          end
        end
      end
      S_PCT: begin
        // shift-add multiply pct * size, one bit per cycle
        if (pct[cnt_q[4:0]]) acc_d = sum;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd22) state_d = S_WORD;
      end
      S_WORD: begin
        if (cnt_q == 6'd23 && !use_count_q) begin
          // divide product by 6553600 = 100<<16
          need_d = need_prod[61:37];
          cnt_d = 6'd0;
        end
        if (mt_vld) begin
          r_d = mt_word[31:1];
          md_d = 26'd0;
          cnt_d = 6'd0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring remainder, one quotient bit per cycle
        if (rem_q == 25'd0) begin
          state_d = S_DONE;
        end else begin
          md_d = trial[26] ? {md_q[24:0], r_q[30]} : trial[25:0];
          r_d = {r_q[29:0], 1'b0};
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd30) state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || !out_stall) begin
          sel_d = 1'b0;
          if (rem_q != 25'd0) begin
            sel_d = md_q[24:0] < need_q;
            if (md_q[24:0] < need_q) need_d = need_q - 25'd1;
            rem_d = rem_q - 25'd1;
          end
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    r_q <= r_d;
    md_q <= md_d;
    sel_q <= sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q <= 25'd0;
      need_q <= 25'd0;
      cnt_q <= 6'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q <= rem_d;
      need_q <= need_d;
      cnt_q <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid = ovalid_q;
  assign selected_o = sel_q;

`include "group_selection_sampler_assert.svh"
  `GSS_ASSERT(a_need_le_rem, clk_i, rst_ni, (state_q == S_IDLE) |-> (need_q <= rem_q), "need exceeds remaining")
  `GSS_ASSERT(a_busy_idle, clk_i, rst_ni, mt_busy |-> !in_acc, "item taken while seeding")
  `GSS_ASSERT(a_rem_step, clk_i, rst_ni, (state_q == S_DONE && state_d == S_IDLE && rem_q != 25'd0) |=> (rem_q == $past(rem_q) - 25'd1), "remaining did not drop")
endmodule

// ----- hw/rtl/gss_mt.sv -----
// ---------------------------------------------------------------------------
// MT19937 word source
// Seeds its 624-word memory one word per cycle, twists each word through
// S_TW_A, S_TW_B and S_TW_C when the state runs out, and delivers one tempered word on request.
// ---------------------------------------------------------------------------
module gss_mt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic        req_i,
  output logic        busy_o,
  output logic        word_vld_o,
  output logic [31:0] word_o
);
  typedef enum logic [6:0] {
    S_SEED  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_TW_A  = 7'b0000100,
    S_TW_B  = 7'b0001000,
    S_TW_C  = 7'b0010000,
    S_RD    = 7'b0100000,
    S_OUT   = 7'b1000000
  } mt_state_e;

  logic [31:0] mem [gss_pkg::MtN];
  mt_state_e   state_q, state_d;
  logic [9:0]  idx_q, idx_d;
  logic [9:0]  pos_q, pos_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] rd_q;
  logic [31:0] hi_q, hi_d;
  logic [31:0] lo_q, lo_d;
  logic [31:0] mul_q;
  logic [9:0]  rd_addr;
  logic        we;
  logic [9:0]  wa;
  logic [31:0] wd;
  logic        pend_q, pend_d;
  logic [31:0] y;
  logic [31:0] tw;

  // wrap helpers
  function automatic logic [9:0] wrap(input logic [10:0] v);
    return (v >= 11'(gss_pkg::MtN)) ? 10'(v - 11'(gss_pkg::MtN)) : v[9:0];
  endfunction

  assign y  = {hi_q[31], lo_q[30:0]};
  assign tw = rd_q ^ (y >> 1) ^ (y[0] ? 32'h9908b0df : 32'h0);

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    pos_d = pos_q;
    prev_d = prev_q;
    hi_d = hi_q;
    lo_d = lo_q;
    pend_d = pend_q | req_i;
    rd_addr = idx_q;
    we = 1'b0;
    wa = idx_q;
    wd = tw;
    case (state_q)
      S_SEED: begin
        // two-step: register product, then write
        we = 1'b1;
        wd = mul_q + 32'(idx_q);
        if (idx_q == 10'd0) begin
          wd = prev_q;
        end
        if (idx_q == 10'(gss_pkg::MtN - 1)) begin
          state_d = S_IDLE;
          pos_d = 10'(gss_pkg::MtN);
        end else begin
          idx_d = idx_q + 10'd1;
          prev_d = wd;
        end
      end
      S_IDLE: begin
        if (pend_q | req_i) begin
          if (pos_q == 10'(gss_pkg::MtN)) begin
            state_d = S_TW_A;
            idx_d = 10'd0;
            rd_addr = 10'd0;
          end else begin
            state_d = S_RD;
            rd_addr = pos_q;
          end
        end
      end
      S_TW_A: begin
        hi_d = rd_q;
        rd_addr = wrap({1'b0, idx_q} + 11'd1);
        state_d = S_TW_B;
      end
      S_TW_B: begin
        lo_d = rd_q;
        rd_addr = wrap({1'b0, idx_q} + 11'(gss_pkg::MtM));
        state_d = S_TW_C;
      end
      S_TW_C: begin
        we = 1'b1;
        wa = idx_q;
        if (idx_q == 10'(gss_pkg::MtN - 1)) begin
          pos_d = 10'd0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 10'd1;
          rd_addr = idx_q + 10'd1;
          state_d = S_TW_A;
        end
      end
      S_RD: begin
        // keep the word at the read position on the output register
        rd_addr = pos_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        pos_d = pos_q + 10'd1;
        pend_d = req_i;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (seed_we_i) begin
      state_d = S_SEED;
      idx_d = 10'd0;
      prev_d = seed_i;
      pend_d = 1'b0;
    end
  end

  // memory
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  // seed multiplier, one product per cycle
  always_ff @(posedge clk_i) begin
    mul_q <= 32'd1812433253 * (prev_d ^ (prev_d >> 30));
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SEED;
      idx_q <= 10'd0;
      pos_q <= 10'(gss_pkg::MtN);
      pend_q <= 1'b0;
      prev_q <= gss_pkg::SeedRst;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      pos_q <= pos_d;
      pend_q <= pend_d;
      prev_q <= prev_d;
    end
  end

  assign busy_o = (state_q == S_SEED);
  assign word_vld_o = (state_q == S_OUT);
  assign word_o = gss_pkg::mt_temper(rd_q);
endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// Group selection sampler testbench
// Drives rows through the sampler under random idling on both channels and
// compares every selection flag with an in-bench MT19937 selection predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  localparam int unsigned WordCount = 624;
  localparam int unsigned TapOffset = 397;
  localparam int unsigned SizeCap   = 1 << gss_pkg::GroupBitsDef;
  localparam int unsigned WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic        first_of_group_i;
  logic [24:0] group_size_i;
  logic        out_valid;
  logic        out_stall;
  logic        selected_o;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  group_selection_sampler uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state: register mirror, generator and group counters
  logic [31:0] mt_state [WordCount];
  int unsigned mt_pos;
  logic        count_mode_m;
  logic [24:0] count_m;
  logic [22:0] pct_m;
  logic [24:0] rows_left;
  logic [24:0] rows_wanted;

  bit sel_expected [$];
  int errors;
  int rows_sent;
  int hold_req;
  bit quiet_rx;

  function void mt_load(input logic [31:0] s);
    mt_state[0] = s;
    for (int i = 1; i < WordCount; i++)
      mt_state[i] = 32'd1812433253 * (mt_state[i-1] ^ (mt_state[i-1] >> 30)) + 32'(i);
    mt_pos = WordCount;
  endfunction

  function logic [31:0] mt_draw();
    logic [31:0] y;
    logic [31:0] v;
    if (mt_pos >= WordCount) begin
      for (int i = 0; i < WordCount; i++) begin
        y = (mt_state[i] & 32'h8000_0000) |
            (mt_state[(i + 1) % WordCount] & 32'h7fff_ffff);
        v = mt_state[(i + TapOffset) % WordCount] ^ (y >> 1);
        if (y[0]) v = v ^ 32'h9908_b0df;
        mt_state[i] = v;
      end
      mt_pos = 0;
    end
    y = mt_state[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // work out whether one accepted row is selected
  function bit predict_selection(input logic first, input logic [24:0] size_in);
    logic [31:0] r;
    logic [63:0] p;
    logic [31:0] sz;
    logic [31:0] want;
    bit sel;
    sel = 1'b0;
    if (first) begin
      sz = (32'(size_in) > SizeCap) ? SizeCap : 32'(size_in);
      if (count_mode_m) want = 32'(count_m);
      else begin
        p = (pct_m > gss_pkg::PctFull) ? 64'(gss_pkg::PctFull) : 64'(pct_m);
        want = 32'((p * 64'(sz)) / 64'd6553600);
      end
      if (want > sz) want = sz;
      rows_left = sz[24:0];
      rows_wanted = want[24:0];
    end
    r = mt_draw() >> 1;
    if (rows_left != 0) begin
      if ((r % 32'(rows_left)) < 32'(rows_wanted)) begin
        sel = 1'b1;
        rows_wanted--;
      end
      rows_left--;
    end
    return sel;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // mirror register writes and predict accepted rows
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        gss_pkg::RegSeed:        mt_load(cfg_data_i);
        gss_pkg::RegUseCount:    count_mode_m <= cfg_data_i[0];
        gss_pkg::RegSampleCount: count_m <= cfg_data_i[24:0];
        gss_pkg::RegPercent:     pct_m <= cfg_data_i[22:0];
        default: ;
      endcase
    end
    if (rst_ni && in_valid && !in_stall)
      sel_expected.push_back(predict_selection(first_of_group_i, group_size_i));
  end

  // check each result item against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (sel_expected.size() == 0) report_mismatch("unexpected item", -1, int'(selected_o));
      else begin
        if (selected_o !== sel_expected[0])
          report_mismatch("selected", int'(sel_expected[0]), int'(selected_o));
        void'(sel_expected.pop_front());
      end
    end
  end

  function int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  // receiver stalls: random gaps, quiet stretches and a requested hold-off
  int hold_left;
  int rx_left;
  always @(posedge clk_i) begin
    if (hold_req > 0 && hold_left == 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_left > 0) begin
      out_stall <= 1'b1;
      rx_left--;
    end else if (!quiet_rx && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      rx_left = pick_gap() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= WatchLimit) begin
      $display("tb: errors");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  bit quiet_tx;

  task automatic send_row(input logic first, input logic [24:0] size_in);
    int gap;
    gap = (quiet_tx || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid         <= 1'b1;
    first_of_group_i <= first;
    group_size_i     <= size_in;
    do @(posedge clk_i); while (in_stall);
    rows_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for every expected item, then let the block settle
  task automatic drain();
    @(posedge clk_i);
    in_valid <= 1'b0;
    while (sel_expected.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function logic [24:0] rand_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return 25'($urandom_range(1, 12));
    if (k < 90) return 25'($urandom_range(13, 300));
    if (k < 98) return 25'($urandom_range(1, 32'h1ff_ffff));
    return 25'd0;
  endfunction

  // one group: mostly well formed, sometimes unopened, cut short or overrun
  task automatic send_group();
    logic [24:0] sz;
    int rows;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      repeat ($urandom_range(1, 4)) send_row(1'b0, 25'($urandom));
      return;
    end
    sz = rand_size();
    rows = (sz != 0 && sz <= 40) ? int'(sz) : $urandom_range(1, 20);
    if (k == 1) rows = $urandom_range(1, rows + 3);
    send_row(1'b1, sz);
    repeat (rows - 1) send_row(1'b0, 25'($urandom));
  endtask

  task automatic random_rows(input int n);
    int stop_at;
    stop_at = rows_sent + n;
    while (rows_sent < stop_at) send_group();
  endtask

  // edge sizes and unopened, zero and saturated groups at reset settings, then in percent mode
  task automatic test_directed();
    send_row(1'b0, 25'h1ff_ffff);
    send_row(1'b0, 25'd0);
    send_row(1'b1, 25'd1);
    send_row(1'b0, 25'd5);
    send_row(1'b1, 25'd0);
    send_row(1'b0, 25'd3);
    send_row(1'b1, 25'd3);
    send_row(1'b0, 25'd0);
    send_row(1'b0, 25'd0);
    send_row(1'b1, 25'h100_0000);
    send_row(1'b0, 25'h0aa_aaaa);
    send_row(1'b1, 25'h1ff_ffff);
    send_row(1'b0, 25'h155_5555);
    drain();
    write_reg(gss_pkg::RegUseCount, 32'd0);
    write_reg(gss_pkg::RegPercent, 32'h7f_ffff);
    send_row(1'b1, 25'd4);
    repeat (3) send_row(1'b0, 25'd0);
    send_row(1'b1, 25'h1ff_ffff);
    send_row(1'b0, 25'd0);
    drain();
  endtask

  // sweep register settings with random groups under each
  task automatic test_settings();
    write_reg(gss_pkg::RegSeed, 32'd0);
    write_reg(gss_pkg::RegUseCount, 32'd1);
    write_reg(gss_pkg::RegSampleCount, 32'd0);
    random_rows(150);
    drain();
    write_reg(gss_pkg::RegSeed, 32'hffff_ffff);
    write_reg(gss_pkg::RegSampleCount, 32'h100_0000);
    random_rows(150);
    drain();
    write_reg(gss_pkg::RegSeed, $urandom);
    write_reg(gss_pkg::RegSampleCount, $urandom_range(1, 6));
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    random_rows(200);
    drain();
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    write_reg(gss_pkg::RegUseCount, 32'd0);
    write_reg(gss_pkg::RegPercent, 32'(gss_pkg::PctFull));
    random_rows(150);
    drain();
    write_reg(gss_pkg::RegPercent, 32'd0);
    random_rows(100);
    drain();
    write_reg(gss_pkg::RegSeed, $urandom);
    write_reg(gss_pkg::RegPercent, $urandom_range(1, 32'h7f_ffff));
    random_rows(250);
    drain();
  endtask

  // hold the receiver off while rows keep coming
  task automatic test_backpressure();
    write_reg(gss_pkg::RegUseCount, 32'd1);
    write_reg(gss_pkg::RegSampleCount, $urandom_range(1, 4));
    hold_req = 400;
    quiet_tx = 1'b1;
    random_rows(40);
    quiet_tx = 1'b0;
    random_rows(150);
    drain();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_valid         <= 1'b0;
    first_of_group_i <= 1'b0;
    group_size_i     <= '0;
    out_stall        <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index_i      <= gss_pkg::RegSeed;
    cfg_data_i       <= '0;
    count_mode_m = 1'b1;
    count_m = 25'd1;
    pct_m = '0;
    rows_left = '0;
    rows_wanted = '0;
    mt_load(gss_pkg::SeedRst);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    test_backpressure();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

// ----- group_selection_sampler.f -----
+incdir+hw/rtl
hw/rtl/gss_pkg.sv
hw/rtl/gss_mt.sv
hw/rtl/group_selection_sampler.sv
tb/tb.sv
